@@ rtl/bes_pkg.sv @@
// Shared types, codes and constants of the bumper escape sequencer.
`default_nettype none
package bes_pkg;

    localparam int PHASE_W = 3;

    localparam logic [PHASE_W-1:0] PH_IDLE        = 3'd0;
    localparam logic [PHASE_W-1:0] PH_FRONT_START = 3'd1;
    localparam logic [PHASE_W-1:0] PH_FRONT_WAIT  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LEFT_START  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LEFT_WAIT   = 3'd4;
    localparam logic [PHASE_W-1:0] PH_RIGHT_START = 3'd5;
    localparam logic [PHASE_W-1:0] PH_RIGHT_WAIT  = 3'd6;
    localparam logic [PHASE_W-1:0] PH_WAIT_END    = 3'd7;

    localparam logic [1:0] DIR_FWD   = 2'd0;
    localparam logic [1:0] DIR_BWD   = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_TURN  = 2'd1;
    localparam logic [1:0] CMD_MOVE  = 2'd2;
    localparam logic [1:0] CMD_SPEED = 2'd3;

    localparam logic [1:0] REG_CRUISE_SPEED = 2'd0;
    localparam logic [1:0] REG_BACK_SPEED   = 2'd1;
    localparam logic [1:0] REG_TURN_SPEED   = 2'd2;
    localparam logic [1:0] REG_BUMP_LIMIT   = 2'd3;

    localparam logic [7:0] RST_CRUISE_SPEED = 8'd80;
    localparam logic [7:0] RST_BACK_SPEED   = 8'd60;
    localparam logic [7:0] RST_TURN_SPEED   = 8'd50;
    localparam logic [7:0] RST_BUMP_LIMIT   = 8'd3;

    localparam logic [7:0] FRONT_BACK_LONG  = 8'd180;
    localparam logic [7:0] FRONT_BACK_SHORT = 8'd120;
    localparam logic [7:0] FRONT_TURN_LONG  = 8'd90;
    localparam logic [7:0] FRONT_TURN_SHORT = 8'd50;
    localparam logic [7:0] SIDE_BACK_LONG   = 8'd160;
    localparam logic [7:0] SIDE_BACK_SHORT  = 8'd100;
    localparam logic [7:0] SIDE_TURN_LONG   = 8'd80;
    localparam logic [7:0] SIDE_TURN_SHORT  = 8'd45;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [7:0]         bump_cnt;
        logic [7:0]         esc_speed;
        logic [1:0]         esc_dir;
        logic               moving;
        logic               rotating;
        logic [7:0]         pending_amount;
    } esc_state_t;

    typedef struct packed {
        logic [7:0] cruise_speed;
        logic [7:0] back_speed;
        logic [7:0] turn_speed;
        logic [7:0] bump_limit;
    } esc_cfg_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] command;
        logic [1:0] direction;
        logic [7:0] spd_left;
        logic [7:0] spd_right;
        logic [7:0] amount;
    } esc_result_t;

endpackage
`default_nettype wire

@@ rtl/bumper_escape_sequencer_top.sv @@
// Top level of the bumper escape sequencer: stream ports, config, state and result registers.
//
// Input beats on s_* carry either a bumper change (s_tuser = 1) or a controller
// tick (s_tuser = 0). A bumper beat only sets the escape phase and yields no
// result; a tick runs one controller pass and yields zero or one command beat
// on m_*, with the command code on m_tuser.
// Each input beat lands in an input register; the pass runs on the registered
// beat in one level of compare-and-select logic and its result loads the
// output register. One beat per cycle is sustained as long as the receiver
// takes results.
// When the receiver stalls, the pending result holds on m_*, the pass for the
// registered input waits, and s_tready drops once the input register is full.
// Configuration writes on cfg_* are to be made while idle; the block does not enforce it.
// Synchronous reset (aresetn low) loads the register defaults (cruise 80,
// back-off 60, turn 50, bump limit 3), clears the escape state to idle and
// empties both registers.
`default_nettype none
module bumper_escape_sequencer_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // cfg_wdata: register value, index from cfg_addr
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: [0] left bumper, [1] right bumper, [2] movement_done, [7:3] zero
    input  wire logic [7:0]  s_tdata,
    // s_tuser: [0] req_type
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: [1:0] direction, [9:2] left speed, [17:10] right speed,
    //          [25:18] amount, [31:26] zero
    output logic [31:0]      m_tdata,
    // m_tuser: [1:0] command
    output logic [1:0]       m_tuser
);

    bes_pkg::esc_cfg_t    cfg_reg;
    bes_pkg::esc_state_t  state_reg;
    bes_pkg::esc_state_t  state_next;
    bes_pkg::esc_result_t res;

    logic       in_valid_reg;
    logic       in_bump_reg;
    logic [2:0] in_data_reg;
    logic       out_valid_reg;
    logic [1:0] out_cmd_reg;
    logic [1:0] out_dir_reg;
    logic [7:0] out_sl_reg;
    logic [7:0] out_sr_reg;
    logic [7:0] out_amt_reg;
    logic       proc;

    // run the pass only when the output register is free or draining
    assign proc     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || proc;

    bes_step u_step (
        .cur           (state_reg),
        .cfg           (cfg_reg),
        .is_bump       (in_bump_reg),
        .bump_l        (in_data_reg[0]),
        .bump_r        (in_data_reg[1]),
        .movement_done (in_data_reg[2]),
        .nxt           (state_next),
        .res           (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cruise_speed <= bes_pkg::RST_CRUISE_SPEED;
            cfg_reg.back_speed   <= bes_pkg::RST_BACK_SPEED;
            cfg_reg.turn_speed   <= bes_pkg::RST_TURN_SPEED;
            cfg_reg.bump_limit   <= bes_pkg::RST_BUMP_LIMIT;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                bes_pkg::REG_CRUISE_SPEED: cfg_reg.cruise_speed <= cfg_wdata;
                bes_pkg::REG_BACK_SPEED:   cfg_reg.back_speed   <= cfg_wdata;
                bes_pkg::REG_TURN_SPEED:   cfg_reg.turn_speed   <= cfg_wdata;
                bes_pkg::REG_BUMP_LIMIT:   cfg_reg.bump_limit   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (proc) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_bump_reg <= s_tuser;
            in_data_reg <= s_tdata[2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc) begin
            out_valid_reg <= res.valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && res.valid) begin
            out_cmd_reg <= res.command;
            out_dir_reg <= res.direction;
            out_sl_reg  <= res.spd_left;
            out_sr_reg  <= res.spd_right;
            out_amt_reg <= res.amount;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_cmd_reg;
    assign m_tdata  = {6'd0, out_amt_reg, out_sr_reg, out_sl_reg, out_dir_reg};

`ifndef SYNTH
    // a bumper beat never produces a result
    a_bump_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && in_bump_reg |=> !m_tvalid)
        else $error("bumper beat produced a result");

    // an escape move is always a back-off
    a_move_backward: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == bes_pkg::CMD_MOVE) |-> (m_tdata[1:0] == bes_pkg::DIR_BWD))
        else $error("escape move not backward");

    // right wheel speed only set by a set-speed command
    a_sr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != bes_pkg::CMD_SPEED) |-> (m_tdata[17:10] == 8'd0))
        else $error("nonzero right speed on move or turn");

    // input side stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");
`endif

endmodule
`default_nettype wire

@@ rtl/bes_step.sv @@
// One controller pass: next escape state and the optional result for one item.
`default_nettype none
module bes_step (
    input  wire bes_pkg::esc_state_t  cur,
    input  wire bes_pkg::esc_cfg_t    cfg,
    input  wire logic                 is_bump,
    input  wire logic                 bump_l,
    input  wire logic                 bump_r,
    input  wire logic                 movement_done,
    output bes_pkg::esc_state_t       nxt,
    output bes_pkg::esc_result_t      res
);

    always_comb begin
        logic over;
        logic [7:0] amt;
        nxt  = cur;
        res  = '0;
        over = (cur.bump_cnt > cfg.bump_limit);
        amt  = '0;

        if (is_bump) begin
            if (bump_l && bump_r) begin
                nxt.phase = bes_pkg::PH_FRONT_START;
            end else if ((bump_l || bump_r) &&
                         (cur.phase != bes_pkg::PH_FRONT_WAIT)) begin
                nxt.phase = bump_l ? bes_pkg::PH_LEFT_START : bes_pkg::PH_RIGHT_START;
            end
        end else begin
            // advance the escape phase
            case (cur.phase)
                bes_pkg::PH_FRONT_START: begin
                    nxt.esc_speed      = cfg.back_speed;
                    nxt.esc_dir        = bes_pkg::DIR_BWD;
                    nxt.moving         = 1'b1;
                    nxt.pending_amount = over ? bes_pkg::FRONT_BACK_LONG
                                              : bes_pkg::FRONT_BACK_SHORT;
                    nxt.phase          = bes_pkg::PH_FRONT_WAIT;
                    nxt.bump_cnt       = cur.bump_cnt + 8'd2;
                end
                bes_pkg::PH_LEFT_START, bes_pkg::PH_RIGHT_START: begin
                    nxt.esc_speed      = cfg.back_speed;
                    nxt.esc_dir        = bes_pkg::DIR_BWD;
                    nxt.moving         = 1'b1;
                    nxt.pending_amount = over ? bes_pkg::SIDE_BACK_LONG
                                              : bes_pkg::SIDE_BACK_SHORT;
                    nxt.phase          = (cur.phase == bes_pkg::PH_LEFT_START)
                                         ? bes_pkg::PH_LEFT_WAIT : bes_pkg::PH_RIGHT_WAIT;
                    nxt.bump_cnt       = cur.bump_cnt + 8'd1;
                end
                bes_pkg::PH_FRONT_WAIT: begin
                    if (!cur.moving) begin
                        nxt.esc_speed = cfg.turn_speed;
                        nxt.rotating  = 1'b1;
                        nxt.phase     = bes_pkg::PH_WAIT_END;
                        if (over) begin
                            nxt.pending_amount = bes_pkg::FRONT_TURN_LONG;
                            nxt.esc_dir        = bes_pkg::DIR_RIGHT;
                            nxt.bump_cnt       = '0;
                        end else begin
                            nxt.pending_amount = bes_pkg::FRONT_TURN_SHORT;
                            nxt.esc_dir        = bes_pkg::DIR_LEFT;
                        end
                    end
                end
                bes_pkg::PH_LEFT_WAIT, bes_pkg::PH_RIGHT_WAIT: begin
                    if (!cur.moving) begin
                        nxt.esc_speed = cfg.turn_speed;
                        nxt.esc_dir   = (cur.phase == bes_pkg::PH_LEFT_WAIT)
                                        ? bes_pkg::DIR_RIGHT : bes_pkg::DIR_LEFT;
                        nxt.rotating  = 1'b1;
                        nxt.phase     = bes_pkg::PH_WAIT_END;
                        if (over) begin
                            nxt.pending_amount = bes_pkg::SIDE_TURN_LONG;
                            nxt.bump_cnt       = '0;
                        end else begin
                            nxt.pending_amount = bes_pkg::SIDE_TURN_SHORT;
                        end
                    end
                end
                bes_pkg::PH_WAIT_END: begin
                    if (!(cur.moving || cur.rotating)) begin
                        nxt.phase = bes_pkg::PH_IDLE;
                    end
                end
                default: begin
                end
            endcase

            // pick the command for this pass
            if (nxt.phase == bes_pkg::PH_IDLE) begin
                res.valid     = 1'b1;
                res.command   = bes_pkg::CMD_SPEED;
                res.direction = bes_pkg::DIR_FWD;
                res.spd_left  = cfg.cruise_speed;
                res.spd_right = cfg.cruise_speed;
            end else if (nxt.pending_amount != 8'd0) begin
                amt                = nxt.pending_amount;
                nxt.pending_amount = '0;
                if (nxt.rotating || nxt.moving) begin
                    res.valid     = 1'b1;
                    res.command   = nxt.rotating ? bes_pkg::CMD_TURN : bes_pkg::CMD_MOVE;
                    res.direction = nxt.esc_dir;
                    res.spd_left  = nxt.esc_speed;
                    res.amount    = amt;
                end
            end else if (!(nxt.moving || nxt.rotating)) begin
                res.valid     = 1'b1;
                res.command   = bes_pkg::CMD_SPEED;
                res.direction = nxt.esc_dir;
                res.spd_left  = nxt.esc_speed;
            end else if (movement_done) begin
                nxt.moving   = 1'b0;
                nxt.rotating = 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the bumper escape sequencer: stream driver, monitor and predictor.
`timescale 1ns / 1ps
module tb;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic is_bump;
        logic left;
        logic right;
        logic done;
    } sensor_beat_t;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] direction;
        logic [7:0] spd_left;
        logic [7:0] spd_right;
        logic [7:0] amount;
    } drive_cmd_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    bumper_escape_sequencer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    sensor_beat_t sensor_beats[$];
    drive_cmd_t   drive_cmds_due[$];
    int unsigned  n_queued = 0;
    int unsigned  n_accepted = 0;
    int unsigned  n_errors = 0;
    int unsigned  cycle_count = 0;

    // shadow of the block's registers and escape state
    logic [7:0] cfg_cruise = bes_pkg::RST_CRUISE_SPEED;
    logic [7:0] cfg_back   = bes_pkg::RST_BACK_SPEED;
    logic [7:0] cfg_turn   = bes_pkg::RST_TURN_SPEED;
    logic [7:0] cfg_limit  = bes_pkg::RST_BUMP_LIMIT;
    logic [2:0] phase      = bes_pkg::PH_IDLE;
    logic [7:0] bump_cnt   = '0;
    logic [7:0] esc_speed  = '0;
    logic [1:0] esc_dir    = bes_pkg::DIR_FWD;
    logic       moving     = 1'b0;
    logic       rotating   = 1'b0;
    logic [7:0] pend_amt   = '0;

    function automatic void queue_cmd(input logic [1:0] cmd, input logic [1:0] dir,
                                      input logic [7:0] sl, input logic [7:0] sr,
                                      input logic [7:0] amt);
        drive_cmd_t c;
        c.command = cmd;
        c.direction = dir;
        c.spd_left = sl;
        c.spd_right = sr;
        c.amount = amt;
        drive_cmds_due.push_back(c);
    endfunction

    function automatic void begin_backoff(input logic [2:0] next_ph, input logic [7:0] long_d,
                                          input logic [7:0] short_d, input logic [7:0] inc);
        esc_speed = cfg_back;
        esc_dir = bes_pkg::DIR_BWD;
        moving = 1'b1;
        pend_amt = (bump_cnt > cfg_limit) ? long_d : short_d;
        phase = next_ph;
        bump_cnt = bump_cnt + inc;
    endfunction

    function automatic void side_turn(input logic [1:0] dir);
        esc_speed = cfg_turn;
        esc_dir = dir;
        rotating = 1'b1;
        if (bump_cnt > cfg_limit) begin
            pend_amt = bes_pkg::SIDE_TURN_LONG;
            bump_cnt = '0;
        end else begin
            pend_amt = bes_pkg::SIDE_TURN_SHORT;
        end
        phase = bes_pkg::PH_WAIT_END;
    endfunction

    // one escape controller pass, or a phase update for a bumper beat
    function automatic void escape_step(input sensor_beat_t b);
        logic [7:0] amt;
        if (b.is_bump) begin
            if (b.left && b.right) begin
                phase = bes_pkg::PH_FRONT_START;
            end else if (b.left || b.right) begin
                if (phase != bes_pkg::PH_FRONT_WAIT)
                    phase = b.left ? bes_pkg::PH_LEFT_START : bes_pkg::PH_RIGHT_START;
            end
            return;
        end
        case (phase)
            bes_pkg::PH_FRONT_START:
                begin_backoff(bes_pkg::PH_FRONT_WAIT, bes_pkg::FRONT_BACK_LONG,
                              bes_pkg::FRONT_BACK_SHORT, 8'd2);
            bes_pkg::PH_FRONT_WAIT: begin
                if (!moving) begin
                    esc_speed = cfg_turn;
                    if (bump_cnt > cfg_limit) begin
                        pend_amt = bes_pkg::FRONT_TURN_LONG;
                        esc_dir = bes_pkg::DIR_RIGHT;
                        bump_cnt = '0;
                    end else begin
                        esc_dir = bes_pkg::DIR_LEFT;
                        pend_amt = bes_pkg::FRONT_TURN_SHORT;
                    end
                    rotating = 1'b1;
                    phase = bes_pkg::PH_WAIT_END;
                end
            end
            bes_pkg::PH_LEFT_START:
                begin_backoff(bes_pkg::PH_LEFT_WAIT, bes_pkg::SIDE_BACK_LONG,
                              bes_pkg::SIDE_BACK_SHORT, 8'd1);
            bes_pkg::PH_LEFT_WAIT: if (!moving) side_turn(bes_pkg::DIR_RIGHT);
            bes_pkg::PH_RIGHT_START:
                begin_backoff(bes_pkg::PH_RIGHT_WAIT, bes_pkg::SIDE_BACK_LONG,
                              bes_pkg::SIDE_BACK_SHORT, 8'd1);
            bes_pkg::PH_RIGHT_WAIT: if (!moving) side_turn(bes_pkg::DIR_LEFT);
            bes_pkg::PH_WAIT_END: if (!(moving || rotating)) phase = bes_pkg::PH_IDLE;
            default: ;
        endcase
        if (phase == bes_pkg::PH_IDLE) begin
            queue_cmd(bes_pkg::CMD_SPEED, bes_pkg::DIR_FWD, cfg_cruise, cfg_cruise, 8'd0);
            return;
        end
        if (pend_amt != 0) begin
            amt = pend_amt;
            pend_amt = '0;
            // a turn in flight wins over the new move
            if (rotating)
                queue_cmd(bes_pkg::CMD_TURN, esc_dir, esc_speed, 8'd0, amt);
            else if (moving)
                queue_cmd(bes_pkg::CMD_MOVE, esc_dir, esc_speed, 8'd0, amt);
            return;
        end
        if (!(moving || rotating)) begin
            queue_cmd(bes_pkg::CMD_SPEED, esc_dir, esc_speed, 8'd0, 8'd0);
            return;
        end
        if (b.done) begin
            moving = 1'b0;
            rotating = 1'b0;
        end
    endfunction

    // sender: one beat in flight, random gap drawn per beat outside of gap-free bursts
    int unsigned  send_gap = 0;
    int unsigned  send_burst = 0;
    sensor_beat_t beat_on_bus;

    always @(posedge aclk) begin : sender
        logic busy;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            busy = s_tvalid;
            if (s_tvalid && s_tready) begin
                escape_step(beat_on_bus);
                n_accepted++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (sensor_beats.size() > 0) begin
                    beat_on_bus = sensor_beats.pop_front();
                    s_tdata <= {5'b0, beat_on_bus.done, beat_on_bus.right, beat_on_bus.left};
                    s_tuser <= beat_on_bus.is_bump;
                    busy = 1'b1;
                    if (send_burst > 0) begin
                        send_burst--;
                        send_gap = 0;
                    end else if ($urandom_range(0, 19) == 0) begin
                        send_burst = $urandom_range(10, 40);
                        send_gap = 0;
                    end else begin
                        send_gap = $urandom_range(0, 6);
                    end
                end
            end
            s_tvalid <= busy;
        end
    end

    // receiver: random stall after each beat outside of bursts, two long hold-offs to back up the input
    int unsigned recv_stall = 0;
    int unsigned recv_burst = 0;
    int unsigned n_results = 0;
    int unsigned recv_hold = 0;
    int unsigned n_holds = 0;
    logic        hold_off = 1'b0;

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge aclk) begin : receiver
        drive_cmd_t want;
        logic rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (drive_cmds_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual cmd %0d data %h",
                             $time, m_tuser, m_tdata);
                    n_errors++;
                end else begin
                    want = drive_cmds_due.pop_front();
                    check_field("command", want.command, m_tuser);
                    check_field("direction", want.direction, m_tdata[1:0]);
                    check_field("spd_left", want.spd_left, m_tdata[9:2]);
                    check_field("spd_right", want.spd_right, m_tdata[17:10]);
                    check_field("amount", want.amount, m_tdata[25:18]);
                end
                if (recv_burst > 0) begin
                    recv_burst--;
                    recv_stall = 0;
                end else if ($urandom_range(0, 19) == 0) begin
                    recv_burst = $urandom_range(10, 40);
                    recv_stall = 0;
                end else begin
                    recv_stall = $urandom_range(0, 6);
                end
            end
            if (hold_off) begin
                rdy = 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_tready <= rdy;
        end
    end

    // long hold-offs of the receiver, counted here cycle by cycle
    always @(posedge aclk) begin : hold_timer
        if (!aresetn) begin
            recv_hold = 0;
        end else if (recv_hold > 0) begin
            recv_hold--;
        end else if ((n_holds == 0 && n_results >= 150) ||
                     (n_holds == 1 && n_results >= 450)) begin
            recv_hold = $urandom_range(150, 250);
            n_holds++;
        end
        hold_off <= (recv_hold > 0);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic queue_beat(input logic is_bump, input logic left, input logic right,
                              input logic done);
        sensor_beat_t b;
        b.is_bump = is_bump;
        b.left = left;
        b.right = right;
        b.done = done;
        sensor_beats.push_back(b);
        n_queued++;
    endtask

    task automatic queue_tick(input logic done);
        queue_beat(1'b0, 1'($urandom), 1'($urandom), done);
    endtask

    task automatic queue_bump(input logic left, input logic right);
        queue_beat(1'b1, left, right, 1'($urandom));
    endtask

    // mostly full escape episodes with random content, the rest noise
    task automatic queue_random(input int unsigned n);
        int unsigned start;
        int unsigned kind;
        int unsigned ticks;
        start = n_queued;
        while (n_queued - start < n) begin
            if ($urandom_range(0, 4) != 0) begin
                kind = $urandom_range(0, 2);
                queue_bump(kind != 2, kind != 1);
                ticks = $urandom_range(2, 10);
                repeat (ticks) begin
                    if ($urandom_range(0, 9) == 0)
                        queue_bump(1'($urandom), 1'($urandom));
                    queue_tick($urandom_range(0, 4) < 2);
                end
            end else begin
                repeat ($urandom_range(1, 4))
                    queue_beat(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
            end
        end
    endtask

    // wait until every beat is taken and every result has arrived, then let the pipe drain
    task automatic wait_drained();
        @(posedge aclk);
        while (n_accepted != n_queued || drive_cmds_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            bes_pkg::REG_CRUISE_SPEED: cfg_cruise = val;
            bes_pkg::REG_BACK_SPEED:   cfg_back = val;
            bes_pkg::REG_TURN_SPEED:   cfg_turn = val;
            bes_pkg::REG_BUMP_LIMIT:   cfg_limit = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [7:0] cruise, input logic [7:0] back,
                             input logic [7:0] turn, input logic [7:0] limit);
        write_reg(bes_pkg::REG_CRUISE_SPEED, cruise);
        write_reg(bes_pkg::REG_BACK_SPEED, back);
        write_reg(bes_pkg::REG_TURN_SPEED, turn);
        write_reg(bes_pkg::REG_BUMP_LIMIT, limit);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed pass at reset defaults
        queue_beat(1'b0, 1'b0, 1'b0, 1'b0);   // cruise
        queue_beat(1'b1, 1'b0, 1'b0, 1'b0);   // no bumper: ignored
        queue_beat(1'b0, 1'b0, 1'b0, 1'b1);
        queue_beat(1'b1, 1'b1, 1'b1, 1'b0);   // front escape
        queue_beat(1'b0, 1'b0, 1'b0, 1'b0);   // back-off move
        queue_beat(1'b1, 1'b1, 1'b0, 1'b0);   // side bump while front waits: ignored
        queue_beat(1'b0, 1'b0, 1'b0, 1'b0);   // still moving
        queue_beat(1'b0, 1'b0, 1'b0, 1'b1);   // move done
        queue_beat(1'b0, 1'b0, 1'b0, 1'b0);   // front turn
        queue_beat(1'b1, 1'b0, 1'b1, 1'b0);   // right bump interrupts the turn
        queue_beat(1'b0, 1'b0, 1'b0, 1'b0);   // turn issued with backward direction
        queue_beat(1'b0, 1'b0, 1'b0, 1'b1);
        queue_beat(1'b0, 1'b0, 1'b0, 1'b0);   // side turn left
        queue_beat(1'b0, 1'b0, 1'b0, 1'b1);
        queue_beat(1'b0, 1'b0, 1'b0, 1'b0);   // back to cruise
        queue_beat(1'b1, 1'b1, 1'b0, 1'b0);   // left escape
        queue_beat(1'b0, 1'b0, 1'b0, 1'b0);
        queue_beat(1'b0, 1'b1, 1'b1, 1'b1);
        queue_beat(1'b0, 1'b0, 1'b0, 1'b0);   // count above limit: long turn, count clears
        queue_beat(1'b0, 1'b0, 1'b0, 1'b1);
        queue_beat(1'b0, 1'b0, 1'b0, 1'b0);
        queue_beat(1'b1, 1'b1, 1'b1, 1'b1);
        queue_beat(1'b0, 1'b1, 1'b1, 1'b1);
        wait_drained();

        write_all(8'd255, 8'd0, 8'd255, 8'd0);
        queue_random(170);
        wait_drained();

        // limit never exceeded: repeated front starts wrap the bump count
        write_all(8'd0, 8'd255, 8'd0, 8'd255);
        repeat (130) begin
            queue_bump(1'b1, 1'b1);
            queue_tick(1'($urandom));
        end
        queue_random(60);
        wait_drained();

        write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(0, 8)));
        queue_random(170);
        wait_drained();

        write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'd1);
        queue_random(150);
        wait_drained();

        if (drive_cmds_due.size() != 0) begin
            $display("%0t: %0d results missing, expected 0 pending, actual %0d",
                     $time, drive_cmds_due.size(), drive_cmds_due.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
